FILE: hdl/fpte_pkg.sv
// fpte_pkg: shared widths, constants, result record and back-end state type
// for the frame pulse timing estimator; no dependencies
package fpte_pkg;

    localparam int LINE_SEL_W    = 5;
    localparam int MAX_SCANS_DEF = 1048576;
    localparam int WORD_BITS_DEF = 32;

    localparam int IDX_OUT_W = 20;
    localparam int COUNT_W   = 20;
    localparam int PERIOD_W  = 28;
    localparam int SPAN_W    = 24;
    localparam int FRAC_W    = 8;
    localparam int DIV_W     = SPAN_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [LINE_SEL_W-1:0] LINE_SEL_RESET = '0;
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = '1;
    localparam logic [COUNT_W-1:0]    MIN_PULSES     = COUNT_W'(2);

    typedef struct packed {
        logic                 valid;
        logic [IDX_OUT_W-1:0] first_start;
        logic [SPAN_W-1:0]    span;
        logic [IDX_OUT_W-1:0] first_width;
        logic [COUNT_W-1:0]   count;
    } t_scan_rec;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } t_back_state;

endpackage

FILE: hdl/fpte_front.sv
// fpte_front: per-sample edge detection and scan bookkeeping, emits one
// scan record on the last sample; depends on fpte_pkg
module fpte_front #(
    parameter int MAX_SCANS = fpte_pkg::MAX_SCANS_DEF,
    parameter int WORD_BITS = fpte_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [fpte_pkg::LINE_SEL_W-1:0] i_line_select,
    input  logic                            i_accept,
    input  logic [WORD_BITS-1:0]            i_sample_word,
    input  logic                            i_last_sample,
    output logic                            o_rec_push,
    output fpte_pkg::t_scan_rec             o_rec
);

    localparam int IDX_W  = $clog2(MAX_SCANS + 1);
    localparam int RISE_W = $clog2(MAX_SCANS);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_SCANS);

    logic                         r_prev, n_prev;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic                         r_start_seen, n_start_seen;
    logic [RISE_W-1:0]            r_first_rise, n_first_rise;
    logic [RISE_W-1:0]            r_last_rise, n_last_rise;
    logic                         r_end_seen, n_end_seen;
    logic [RISE_W-1:0]            r_first_fall, n_first_fall;
    logic [fpte_pkg::COUNT_W-1:0] r_rise_count, n_rise_count;
    logic                         level;
    logic [RISE_W-1:0]            rise_pos;

    always_comb begin
        level = 1'b0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i == int'(i_line_select)) begin
                level = i_sample_word[i];
            end
        end
    end

    assign rise_pos = RISE_W'(r_idx);

    always_comb begin
        n_prev       = r_prev;
        n_idx        = r_idx;
        n_start_seen = r_start_seen;
        n_first_rise = r_first_rise;
        n_last_rise  = r_last_rise;
        n_end_seen   = r_end_seen;
        n_first_fall = r_first_fall;
        n_rise_count = r_rise_count;
        if (r_idx < MAX_IDX) begin
            if (level != r_prev) begin
                if (level) begin
                    if (!r_start_seen) begin
                        n_start_seen = 1'b1;
                        n_first_rise = rise_pos;
                    end
                    n_last_rise = rise_pos;
                    if (r_rise_count != fpte_pkg::COUNT_MAX) begin
                        n_rise_count = r_rise_count + 1'b1;
                    end
                end else if (!r_end_seen) begin
                    n_end_seen   = 1'b1;
                    n_first_fall = rise_pos;
                end
                n_prev = level;
            end
            n_idx = r_idx + 1'b1;
        end
    end

    always_comb begin
        o_rec_push        = i_accept && i_last_sample;
        o_rec.valid       = n_rise_count >= fpte_pkg::MIN_PULSES;
        o_rec.first_start = n_start_seen ? fpte_pkg::IDX_OUT_W'(n_first_rise) : '0;
        o_rec.span        = o_rec.valid ?
                            fpte_pkg::SPAN_W'(n_last_rise - n_first_rise) : '0;
        o_rec.first_width = (n_start_seen && n_end_seen) ?
                            fpte_pkg::IDX_OUT_W'(n_first_fall - n_first_rise) : '0;
        o_rec.count       = n_rise_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= 1'b0;
            r_idx        <= '0;
            r_start_seen <= 1'b0;
            r_first_rise <= '0;
            r_last_rise  <= '0;
            r_end_seen   <= 1'b0;
            r_first_fall <= '0;
            r_rise_count <= '0;
        end else if (i_accept) begin
            if (i_last_sample) begin
                r_prev       <= 1'b0;
                r_idx        <= '0;
                r_start_seen <= 1'b0;
                r_first_rise <= '0;
                r_last_rise  <= '0;
                r_end_seen   <= 1'b0;
                r_first_fall <= '0;
                r_rise_count <= '0;
            end else begin
                r_prev       <= n_prev;
                r_idx        <= n_idx;
                r_start_seen <= n_start_seen;
                r_first_rise <= n_first_rise;
                r_last_rise  <= n_last_rise;
                r_end_seen   <= n_end_seen;
                r_first_fall <= n_first_fall;
                r_rise_count <= n_rise_count;
            end
        end
    end

endmodule

FILE: hdl/fpte_queue.sv
// fpte_queue: small show-ahead queue of scan records between front and back
// depends on fpte_pkg
module fpte_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fpte_pkg::t_scan_rec i_wdata,
    output logic                o_full,
    input  logic                i_pop,
    output fpte_pkg::t_scan_rec o_rdata,
    output logic                o_empty
);

    fpte_pkg::t_scan_rec               r_mem [fpte_pkg::QDEPTH];
    logic [fpte_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [fpte_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [fpte_pkg::QCNT_W-1:0]       r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_full  = r_count == fpte_pkg::QCNT_W'(fpte_pkg::QDEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/fpte_back.sv
// fpte_back: radix-2 restoring divider for the mean period and the result
// output register; depends on fpte_pkg
module fpte_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    input  fpte_pkg::t_scan_rec              i_q_rec,
    output logic                             o_q_pop,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic                             o_timing_valid,
    output logic [fpte_pkg::IDX_OUT_W-1:0]   o_first_start,
    output logic [fpte_pkg::PERIOD_W-1:0]    o_period_q8,
    output logic [fpte_pkg::IDX_OUT_W-1:0]   o_first_width,
    output logic [fpte_pkg::COUNT_W-1:0]     o_pulse_count
);

    fpte_pkg::t_back_state              r_state, n_state;
    fpte_pkg::t_scan_rec                r_rec;
    logic [fpte_pkg::DIV_W-1:0]         r_qr;
    logic [fpte_pkg::COUNT_W-1:0]       r_rem;
    logic [fpte_pkg::COUNT_W-1:0]       r_div;
    logic [fpte_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic                               r_out_valid;
    logic                               load_out;
    logic [fpte_pkg::COUNT_W:0]         rem_sh;
    logic                               ge;
    logic [fpte_pkg::COUNT_W-1:0]       rem_nx;
    logic                               ovf;
    logic [fpte_pkg::PERIOD_W-1:0]      period;

    // one quotient bit per cycle
    assign rem_sh = {r_rem, r_qr[fpte_pkg::DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign rem_nx = ge ? fpte_pkg::COUNT_W'(rem_sh - {1'b0, r_div})
                       : fpte_pkg::COUNT_W'(rem_sh);
    assign ovf    = |r_qr[fpte_pkg::DIV_W-1:fpte_pkg::PERIOD_W];
    assign period = ovf ? '1 : r_qr[fpte_pkg::PERIOD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpte_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            fpte_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = i_q_rec.valid ? fpte_pkg::BK_DIV : fpte_pkg::BK_HOLD;
                end
            end
            fpte_pkg::BK_DIV: begin
                if (r_cnt == fpte_pkg::DIV_CNT_W'(fpte_pkg::DIV_W - 1)) begin
                    n_state = fpte_pkg::BK_HOLD;
                end
            end
            fpte_pkg::BK_HOLD: begin
                if (!r_out_valid || i_pop) begin
                    load_out = 1'b1;
                    n_state  = fpte_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = fpte_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_rec;
            r_qr  <= i_q_rec.valid ? {i_q_rec.span, fpte_pkg::FRAC_W'(0)} : '0;
            r_rem <= '0;
            r_div <= i_q_rec.count - 1'b1;
        end else if (r_state == fpte_pkg::BK_DIV) begin
            r_qr  <= {r_qr[fpte_pkg::DIV_W-2:0], ge};
            r_rem <= rem_nx;
        end
        if (load_out) begin
            o_timing_valid <= r_rec.valid;
            o_first_start  <= r_rec.first_start;
            o_period_q8    <= period;
            o_first_width  <= r_rec.first_width;
            o_pulse_count  <= r_rec.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_cnt <= '0;
            end else if (r_state == fpte_pkg::BK_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;

endmodule

FILE: hdl/frame_pulse_timing_estimator.sv
// frame_pulse_timing_estimator: top level, line select register, front end,
// record queue and divider back end; depends on fpte_pkg and all fpte_ modules
//
//   channel   handshake              payload
//   samples   push / full            i_sample_word, i_last_sample
//   results   pop / empty            o_timing_valid, o_first_start, o_period_q8,
//                                    o_first_width, o_pulse_count
//   config    i_cfg_valid/o_cfg_ready i_cfg_line_select
//
// one sample item per cycle while the record queue has room
// each scan result goes through the back end in 32 divider steps, load and
// hand-over; results with fewer than two pulses skip the divider
// full rises only when two finished scans are queued behind the divider
// synchronous active-low reset clears the scan state, queue and line select
// config writes are always ready
module frame_pulse_timing_estimator #(
    parameter int MAX_SCANS = fpte_pkg::MAX_SCANS_DEF,
    parameter int WORD_BITS = fpte_pkg::WORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fpte_pkg::LINE_SEL_W-1:0]  i_cfg_line_select,
    input  logic                             push,
    output logic                             full,
    input  logic [WORD_BITS-1:0]             i_sample_word,
    input  logic                             i_last_sample,
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_timing_valid,
    output logic [fpte_pkg::IDX_OUT_W-1:0]   o_first_start,
    output logic [fpte_pkg::PERIOD_W-1:0]    o_period_q8,
    output logic [fpte_pkg::IDX_OUT_W-1:0]   o_first_width,
    output logic [fpte_pkg::COUNT_W-1:0]     o_pulse_count
);

    logic [fpte_pkg::LINE_SEL_W-1:0] r_line_select;
    logic                            accept;
    logic                            rec_push;
    fpte_pkg::t_scan_rec             rec_in;
    fpte_pkg::t_scan_rec             rec_out;
    logic                            q_empty;
    logic                            q_pop;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_select <= fpte_pkg::LINE_SEL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_select <= i_cfg_line_select;
        end
    end

    fpte_front #(
        .MAX_SCANS (MAX_SCANS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_select (r_line_select),
        .i_accept      (accept),
        .i_sample_word (i_sample_word),
        .i_last_sample (i_last_sample),
        .o_rec_push    (rec_push),
        .o_rec         (rec_in)
    );

    fpte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_wdata (rec_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_rdata (rec_out),
        .o_empty (q_empty)
    );

    fpte_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_rec        (rec_out),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_timing_valid (o_timing_valid),
        .o_first_start  (o_first_start),
        .o_period_q8    (o_period_q8),
        .o_first_width  (o_first_width),
        .o_pulse_count  (o_pulse_count)
    );

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_timing_valid == (o_pulse_count >= fpte_pkg::MIN_PULSES)))
        else $error("timing_valid disagrees with pulse_count");

    a_no_period_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_timing_valid) |-> (o_period_q8 == '0))
        else $error("period given for a scan with too few pulses");

    a_no_pulse_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_pulse_count == '0)) |-> ((o_first_start == '0) && (o_first_width == '0)))
        else $error("pulse fields set for a scan without pulses");

    a_full_only_with_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> q_pop == 1'b0 || !q_empty)
        else $error("queue full while empty");

endmodule
